FILE: src/vrbs_pkg.sv
// Shared types and constants for the variable record byte stack.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vrbs_pkg;

	// default sizing, handed down from the top level
	localparam int DATA_DEPTH_DEF  = 4096;
	localparam int MAX_RECORDS_DEF = 256;
	localparam int MAX_POP_LEN_DEF = 64;

	// stream widths (fixed by the field layout)
	localparam int IN_TDATA_W  = 16; // push_byte[7:0], byte_present[8], pop_length[15:9]
	localparam int OUT_TDATA_W = 16; // out_byte[7:0], record_index[15:8]
	localparam int OUT_TUSER_W = 3;  // status
	localparam int LEN_W       = 7;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_t;

	typedef enum logic [OUT_TUSER_W-1:0] {
		ST_PUSH_DONE = 3'd0,
		ST_POP_BYTE  = 3'd1,
		ST_POP_NONE  = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_TOO_LONG  = 3'd4,
		ST_NO_SPACE  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_STREAM
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic push;        // push beat taken
		logic pop_start;   // pop beat taken
		logic pop_single;  // pop answered with one result (too long or zero length)
		logic issue;       // read next record byte
		logic load_byte;   // move read byte into output register
		logic finish;      // last byte loaded, drop the record
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;    // output register can take a result this cycle
		logic empty;       // no complete record on the stack
		logic pop_ends;    // looked-up pop ends in one result
		logic pend;        // byte read data waiting
		logic all_issued;  // every requested byte read
		logic last_emit;   // next loaded byte is the last one
	} sts_t;

endpackage

`default_nettype wire

FILE: src/vrbs_ctrl.sv
// Sequencer for the record stack: accepts beats, walks a pop through lookup
// and byte streaming. Depends on vrbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrbs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tuser,
	output logic               s_tready,
	input  vrbs_pkg::sts_t     sts,
	output vrbs_pkg::cmd_t     cmd
);
	import vrbs_pkg::*;

	state_t state_q, state_nxt;
	logic   acc;

	assign acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && s_tuser == REQ_POP && !sts.empty) state_nxt = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (!sts.pop_ends) state_nxt = S_STREAM;
				else if (sts.out_free) state_nxt = S_IDLE;
			end
			S_STREAM: begin
				if (sts.pend && sts.out_free && sts.last_emit) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				s_tready      = sts.out_free;
				cmd.push      = acc && s_tuser == REQ_PUSH;
				cmd.pop_start = acc && s_tuser == REQ_POP;
			end
			S_LOOKUP: begin
				cmd.pop_single = sts.pop_ends && sts.out_free;
			end
			S_STREAM: begin
				cmd.load_byte = sts.pend && sts.out_free;
				cmd.issue     = !sts.all_issued && (!sts.pend || sts.out_free);
				cmd.finish    = sts.pend && sts.out_free && sts.last_emit;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/vrbs_datapath.sv
// Datapath of the record stack: byte memory, start table, fill and count
// registers, pop counters and the output register. Depends on vrbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrbs_datapath #(
	parameter int DATA_DEPTH  = vrbs_pkg::DATA_DEPTH_DEF,
	parameter int MAX_RECORDS = vrbs_pkg::MAX_RECORDS_DEF,
	parameter int MAX_POP_LEN = vrbs_pkg::MAX_POP_LEN_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  vrbs_pkg::cmd_t                       cmd,
	output vrbs_pkg::sts_t                       sts,
	input  wire logic [vrbs_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [vrbs_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [vrbs_pkg::OUT_TUSER_W-1:0]     m_tuser,
	output logic                                 m_tlast
);
	import vrbs_pkg::*;

	localparam int ADDR_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
	localparam int FILL_W = $clog2(DATA_DEPTH + 1);
	localparam int IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

	// stores, no reset
	logic [7:0]        byte_mem [DATA_DEPTH];
	logic [FILL_W-1:0] start_mem [MAX_RECORDS];

	// control state
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  count_q;
	logic              open_q;
	logic              failed_q;
	logic [FILL_W-1:0] open_start_q;
	logic [LEN_W-1:0]  iss_q;
	logic [LEN_W-1:0]  emit_q;
	logic              pend_q;
	logic              out_valid_q;

	// payload
	logic [LEN_W-1:0]  len_q;
	logic [FILL_W-1:0] start_q;
	logic [7:0]        rd_byte_q;
	status_t           out_status_q;
	logic [7:0]        out_byte_q;
	logic [7:0]        out_idx_q;
	logic              out_last_q;

	logic [7:0]        in_byte;
	logic              in_present;
	logic [LEN_W-1:0]  in_len;

	logic [FILL_W-1:0] ostart_eff;
	logic              fail_eff;
	logic              mem_full;
	logic              byte_wr;
	logic              fail_nxt;
	logic [FILL_W-1:0] fill_nxt;
	logic              push_bad;
	logic              tbl_wr;
	logic [IDX_W-1:0]  top_idx;
	logic [FILL_W-1:0] rec_size;
	logic              too_long;
	logic              zero_len;
	logic [ADDR_W-1:0] rd_addr;
	logic              drop_rec;

	logic              out_load;
	status_t           res_status;
	logic [7:0]        res_byte;
	logic [7:0]        res_idx;
	logic              res_last;

	assign in_byte    = s_tdata[7:0];
	assign in_present = s_tdata[8];
	assign in_len     = s_tdata[15:9];

	// push decode
	assign ostart_eff = open_q ? open_start_q : fill_q;
	assign fail_eff   = open_q && failed_q;
	assign mem_full   = fill_q >= FILL_W'(DATA_DEPTH);
	assign byte_wr    = cmd.push && in_present && !fail_eff && !mem_full;
	assign fail_nxt   = fail_eff || (in_present && mem_full);
	assign fill_nxt   = byte_wr ? fill_q + FILL_W'(1) : fill_q;
	assign push_bad   = fail_nxt || (count_q >= CNT_W'(MAX_RECORDS));
	assign tbl_wr     = cmd.push && s_tlast && !push_bad;

	// pop decode
	assign top_idx  = IDX_W'(count_q - CNT_W'(1));
	assign rec_size = (fill_q >= start_q) ? fill_q - start_q : '0;
	assign too_long = (FILL_W'(len_q) > rec_size) || (len_q > LEN_W'(MAX_POP_LEN));
	assign zero_len = len_q == '0;
	assign rd_addr  = ADDR_W'(start_q + FILL_W'(iss_q));
	assign drop_rec = (cmd.pop_single && !too_long && zero_len) || cmd.finish;

	assign sts.out_free   = !out_valid_q || m_tready;
	assign sts.empty      = count_q == '0;
	assign sts.pop_ends   = too_long || zero_len;
	assign sts.pend       = pend_q;
	assign sts.all_issued = iss_q == len_q;
	assign sts.last_emit  = (emit_q + LEN_W'(1)) == len_q;

	// result select
	always_comb begin
		out_load   = 1'b0;
		res_status = ST_PUSH_DONE;
		res_byte   = '0;
		res_idx    = '0;
		res_last   = 1'b1;
		if (cmd.push && s_tlast) begin
			out_load   = 1'b1;
			res_status = push_bad ? ST_NO_SPACE : ST_PUSH_DONE;
			res_idx    = push_bad ? 8'd0 : 8'(count_q);
		end else if (cmd.pop_start && sts.empty) begin
			out_load   = 1'b1;
			res_status = ST_EMPTY;
		end else if (cmd.pop_single) begin
			out_load   = 1'b1;
			res_status = too_long ? ST_TOO_LONG : ST_POP_NONE;
			res_idx    = 8'(top_idx);
		end else if (cmd.load_byte) begin
			out_load   = 1'b1;
			res_status = ST_POP_BYTE;
			res_byte   = rd_byte_q;
			res_idx    = 8'(top_idx);
			res_last   = sts.last_emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			count_q      <= '0;
			open_q       <= 1'b0;
			failed_q     <= 1'b0;
			open_start_q <= '0;
			iss_q        <= '0;
			emit_q       <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				if (s_tlast) begin
					open_q   <= 1'b0;
					failed_q <= 1'b0;
					if (push_bad) begin
						fill_q <= ostart_eff;
					end else begin
						fill_q  <= fill_nxt;
						count_q <= count_q + CNT_W'(1);
					end
				end else begin
					open_q       <= 1'b1;
					failed_q     <= fail_nxt;
					open_start_q <= ostart_eff;
					fill_q       <= fill_nxt;
				end
			end
			if (cmd.pop_start) begin
				// a partial record is dropped silently
				if (open_q) fill_q <= open_start_q;
				open_q   <= 1'b0;
				failed_q <= 1'b0;
				iss_q    <= '0;
				emit_q   <= '0;
				pend_q   <= 1'b0;
			end
			if (drop_rec) begin
				fill_q  <= start_q;
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.issue) iss_q <= iss_q + LEN_W'(1);
			if (cmd.load_byte) emit_q <= emit_q + LEN_W'(1);
			if (cmd.issue) pend_q <= 1'b1;
			else if (cmd.load_byte) pend_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_start) len_q <= in_len;
		if (out_load) begin
			out_status_q <= res_status;
			out_byte_q   <= res_byte;
			out_idx_q    <= res_idx;
			out_last_q   <= res_last;
		end
	end

	// byte memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (byte_wr) byte_mem[fill_q[ADDR_W-1:0]] <= in_byte;
		if (cmd.issue) rd_byte_q <= byte_mem[rd_addr];
	end

	// start table: one write, one registered read
	always_ff @(posedge clk) begin
		if (tbl_wr) start_mem[count_q[IDX_W-1:0]] <= ostart_eff;
		if (cmd.pop_start) start_q <= start_mem[top_idx];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_idx_q, out_byte_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: src/variable_record_byte_stack.sv
// Top level of the variable record byte stack; ties sequencer and datapath.
// Depends on vrbs_pkg, vrbs_ctrl and vrbs_datapath.
// Push beats: at most one per cycle; the closing beat's result is valid from the
// accepting edge on, as is an empty-stack pop's; another pop answered by one
// result has it valid from the edge after that. Byte pop: lookup, read, load,
// then one byte per cycle while the output is free; next beat taken in idle.
// Reset (arst_n, async): clears fill, record count and handshake state; the
// memories keep their contents and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module variable_record_byte_stack #(
	parameter int DATA_DEPTH  = vrbs_pkg::DATA_DEPTH_DEF,
	parameter int MAX_RECORDS = vrbs_pkg::MAX_RECORDS_DEF,
	parameter int MAX_POP_LEN = vrbs_pkg::MAX_POP_LEN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request side
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// push_byte[7:0], byte_present[8], pop_length[15:9]
	input  wire logic [vrbs_pkg::IN_TDATA_W-1:0]  s_tdata,
	// req_type: 0 push beat, 1 pop
	input  wire logic                             s_tuser,
	// end_of_record
	input  wire logic                             s_tlast,
	// result side
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// out_byte[7:0], record_index[15:8]
	output logic [vrbs_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// status[2:0]
	output logic [vrbs_pkg::OUT_TUSER_W-1:0]      m_tuser,
	// last result of the request
	output logic                                  m_tlast
);
	import vrbs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer: idle takes beats only when the output register is free, so a
	// closing push or an empty-stack pop can always post its result at once.
	vrbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: the stores, the stack pointers and the output register.
	vrbs_datapath #(
		.DATA_DEPTH  (DATA_DEPTH),
		.MAX_RECORDS (MAX_RECORDS),
		.MAX_POP_LEN (MAX_POP_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

FILE: src/vrbs_checker.sv
// Port-level checks on the record stack's result stream, bound to the top.
// Depends on vrbs_pkg and variable_record_byte_stack.
`timescale 1ns / 1ps
`default_nettype none

module vrbs_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [vrbs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic [vrbs_pkg::OUT_TUSER_W-1:0] m_tuser,
	input wire logic                             m_tlast
);
	import vrbs_pkg::*;

	// only a pop byte carries data
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_POP_BYTE |-> m_tdata[7:0] == 8'd0)
		else $error("nonzero out_byte on a non-byte result");

	// every result but a pop byte is a single-beat answer
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_POP_BYTE |-> m_tlast)
		else $error("single result without last");

	// empty and out-of-space answers carry index zero
	a_err_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_NO_SPACE)
		|-> m_tdata[15:8] == 8'd0)
		else $error("error result with nonzero record index");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

endmodule

bind variable_record_byte_stack vrbs_checker u_vrbs_checker (.*);

`default_nettype wire

FILE: sim/variable_record_byte_stack_tb.sv
// Self-checking bench for variable_record_byte_stack: push/pop beats in, result beats checked.
// Depends on vrbs_pkg and variable_record_byte_stack; holds its own stack model for prediction.
`timescale 1ns / 1ps

module variable_record_byte_stack_tb;
	import vrbs_pkg::*;

	localparam int BYTE_CAP     = DATA_DEPTH_DEF;
	localparam int RECORD_CAP   = MAX_RECORDS_DEF;
	localparam int POP_CAP      = MAX_POP_LEN_DEF;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int TAIL_CYCLES  = 40;

	typedef struct {
		req_t       kind;
		logic [7:0] data;
		logic       has_byte;
		logic       eor;
		logic [6:0] pop_len;
	} stack_cmd_t;

	typedef struct {
		status_t    status;
		logic [7:0] data;
		logic [7:0] idx;
		logic       is_last;
	} stack_reply_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic m_tlast;

	// knobs shared by stimulus and receiver
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	int beats_sent = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// stack model
	logic [7:0]  mem_bytes [BYTE_CAP];
	logic [12:0] rec_start [RECORD_CAP];
	logic [12:0] fill = '0;
	logic [8:0]  nrec = '0;
	logic [12:0] open_at = '0;
	bit rec_open = 1'b0;
	bit rec_failed = 1'b0;

	stack_reply_t expected_replies[$];
	int gen_sizes[$];	// sizes of complete records, as the random stimulus sees them

	always #6 clk = ~clk;

	variable_record_byte_stack #(
		.DATA_DEPTH(BYTE_CAP),
		.MAX_RECORDS(RECORD_CAP),
		.MAX_POP_LEN(POP_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	function automatic void expect_reply(input status_t st, input logic [7:0] data,
			input logic [7:0] idx, input bit is_last);
		stack_reply_t r;
		r.status = st;
		r.data = data;
		r.idx = idx;
		r.is_last = is_last;
		expected_replies.push_back(r);
	endfunction

	function automatic void predict_stack(input stack_cmd_t c);
		logic [12:0] base;
		logic [12:0] size;
		logic [8:0]  top;
		if (c.kind == REQ_PUSH) begin
			if (!rec_open) begin
				rec_open = 1'b1;
				rec_failed = 1'b0;
				open_at = fill;
			end
			if (c.has_byte && !rec_failed) begin
				if (fill >= BYTE_CAP)
					rec_failed = 1'b1;
				else begin
					mem_bytes[fill] = c.data;
					fill++;
				end
			end
			if (c.eor) begin
				rec_open = 1'b0;
				if (rec_failed || nrec >= RECORD_CAP) begin
					// record dropped whole, space handed back
					fill = open_at;
					rec_failed = 1'b0;
					expect_reply(ST_NO_SPACE, 8'h00, 8'h00, 1'b1);
				end else begin
					rec_start[nrec] = open_at;
					expect_reply(ST_PUSH_DONE, 8'h00, nrec[7:0], 1'b1);
					nrec++;
				end
			end
		end else begin
			// a pop silently drops any half-pushed record
			if (rec_open) begin
				fill = open_at;
				rec_open = 1'b0;
				rec_failed = 1'b0;
			end
			if (nrec == 0)
				expect_reply(ST_EMPTY, 8'h00, 8'h00, 1'b1);
			else begin
				top = nrec - 1;
				base = rec_start[top];
				size = (fill >= base) ? fill - base : '0;
				if (c.pop_len > size || c.pop_len > POP_CAP)
					expect_reply(ST_TOO_LONG, 8'h00, top[7:0], 1'b1);
				else begin
					if (c.pop_len == 0)
						expect_reply(ST_POP_NONE, 8'h00, top[7:0], 1'b1);
					for (int i = 0; i < c.pop_len; i++)
						expect_reply(ST_POP_BYTE, mem_bytes[base + i], top[7:0],
							i == c.pop_len - 1);
					fill = base;
					nrec = top;
				end
			end
		end
	endfunction

	// request monitor: every accepted beat goes through the model
	always @(posedge clk) begin : watch_requests
		stack_cmd_t c;
		if (arst_n && s_tvalid && s_tready) begin
			c.kind = req_t'(s_tuser);
			c.data = s_tdata[7:0];
			c.has_byte = s_tdata[8];
			c.pop_len = s_tdata[15:9];
			c.eor = s_tlast;
			predict_stack(c);
		end
	end

	// result checker: in order against the oldest expectation
	always @(posedge clk) begin : check_results
		stack_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0)
				report_mismatch("result beat with nothing expected", m_tdata, 16'h0);
			else begin
				want = expected_replies.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", m_tuser, want.status);
				if (m_tdata[7:0] !== want.data)
					report_mismatch("out_byte", m_tdata[7:0], want.data);
				if (m_tdata[15:8] !== want.idx)
					report_mismatch("record_index", m_tdata[15:8], want.idx);
				if (m_tlast !== want.is_last)
					report_mismatch("last", m_tlast, want.is_last);
			end
		end
	end

	// receiver: random stalls, or a long hold-off counted down here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("variable_record_byte_stack regression: fail");
		$finish;
	end

	// one beat; idles cycle by cycle first, returns at the edge where it was taken
	task automatic send_beat(input stack_cmd_t c);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c.pop_len, c.has_byte, c.data};
		s_tuser <= c.kind;
		s_tlast <= c.eor;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic push_item(input logic [7:0] data, input bit present, input bit eor);
		stack_cmd_t c;
		c.kind = REQ_PUSH;
		c.data = data;
		c.has_byte = present;
		c.eor = eor;
		c.pop_len = 7'($urandom_range(127));
		send_beat(c);
	endtask

	task automatic pop_item(input logic [6:0] len);
		stack_cmd_t c;
		c.kind = REQ_POP;
		c.data = 8'($urandom_range(255));
		c.has_byte = 1'($urandom_range(1));
		c.eor = 1'($urandom_range(1));
		c.pop_len = len;
		send_beat(c);
	endtask

	// n random bytes; blank_pct mixes in byte-less beats and a byte-less close
	task automatic push_record(input int n, input int blank_pct);
		bit sep_close;
		sep_close = (blank_pct != 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < n; i++) begin
			if (blank_pct != 0 && $urandom_range(99) < blank_pct)
				push_item(8'($urandom_range(255)), 1'b0, 1'b0);
			push_item(8'($urandom_range(255)), 1'b1, (i == n - 1) && !sep_close);
		end
		if (n == 0 || sep_close)
			push_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// the edge that took the last beat has passed before the queue is looked at
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_and_short_pops();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		pop_item(7'd0);			// empty stack
		pop_item(7'd127);		// empty stack, all length bits set
		push_item(8'h5A, 1'b0, 1'b1);	// empty record
		pop_item(7'd1);			// longer than the empty record
		pop_item(7'd0);			// zero-length pop removes it
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'hC3, 1'b0, 1'b0);	// byte-less middle beat
		push_item(8'hFF, 1'b1, 1'b0);
		push_item(8'hA5, 1'b1, 1'b1);
		push_item(8'h11, 1'b1, 1'b0);	// second record left open
		push_item(8'h22, 1'b1, 1'b0);
		pop_item(7'd4);			// drops open record, then too long
		pop_item(7'd2);			// 00 FF, record removed
		push_record(65, 0);
		pop_item(7'd65);		// within record but over the pop cap
		pop_item(7'd127);
		pop_item(7'd64);		// largest pop
		drain_results();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 20;
		repeat (2)
			push_record(8, 0);
		hold_left = 150;
		// sender keeps offering while the receiver holds results back
		repeat (2)
			pop_item(7'd8);
		push_record(4, 0);
		pop_item(7'd4);
		drain_results();
	endtask

	// pop with a given length and keep the size shadow in step
	task automatic pop_tracked(input int len);
		int top_size;
		pop_item(7'(len));
		if (gen_sizes.size() != 0) begin
			top_size = gen_sizes[$];
			if (len <= top_size && len <= POP_CAP)
				void'(gen_sizes.pop_back());
		end
	endtask

	task automatic run_random_phase(input int n_beats, input int tx_pct, input int rx_pct);
		int goal;
		int n;
		int top_size;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		goal = beats_sent + n_beats;
		while (beats_sent < goal) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					n = ($urandom_range(9) == 0) ? $urandom_range(13, 70) :
						$urandom_range(0, 12);
					push_record(n, ($urandom_range(3) == 0) ? 25 : 0);
					gen_sizes.push_back(n);
				end
				5, 6, 7: begin
					if (gen_sizes.size() == 0)
						pop_tracked($urandom_range(0, 127));
					else begin
						top_size = gen_sizes[$];
						if ($urandom_range(4) != 0)
							pop_tracked($urandom_range(0,
								(top_size < POP_CAP) ? top_size : POP_CAP));
						else
							pop_tracked($urandom_range(
								(top_size < POP_CAP) ? top_size + 1 : POP_CAP + 1, 127));
					end
				end
				8: begin
					// half-pushed record abandoned by a pop
					repeat ($urandom_range(1, 5))
						push_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
					pop_tracked($urandom_range(0, 20));
				end
				default:
					pop_tracked($urandom_range(0, 127));
			endcase
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_short_pops();
		test_backpressure();
		run_random_phase(6, 0, 0);
		run_random_phase(6, 70, 0);
		run_random_phase(6, 0, 70);
		run_random_phase(6, 32, 32);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0)
			report_mismatch("results never seen", 16'(expected_replies.size()), 16'h0);
		if (mismatch_count == 0)
			$display("variable_record_byte_stack regression: pass");
		else
			$display("variable_record_byte_stack regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
src/vrbs_pkg.sv
src/vrbs_ctrl.sv
src/vrbs_datapath.sv
src/variable_record_byte_stack.sv
src/vrbs_checker.sv
sim/variable_record_byte_stack_tb.sv
